### rtl/affine_map_inverse_from_matrix_macros.svh
// Assertion macros shared by the affine map inverse RTL.
// Include guarded; no other dependencies.
`ifndef AFFINE_MAP_INVERSE_FROM_MATRIX_MACROS_SVH
`define AFFINE_MAP_INVERSE_FROM_MATRIX_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AMIF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("amif assertion failed");

// Next-cycle implication, disabled during reset.
`define AMIF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("amif assertion failed");

`endif

### rtl/amif_pkg.sv
// Shared constants for the affine map inverse pipeline.
// No dependencies.
package amif_pkg;
   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int LANES         = 6;

   // lane order matches the field order on the data buses
   localparam int L_00 = 0;
   localparam int L_01 = 1;
   localparam int L_10 = 2;
   localparam int L_11 = 3;
   localparam int L_DX = 4;
   localparam int L_DY = 5;

   localparam int USER_SINGULAR = 0;
   localparam int USER_OVERFLOW = 1;
   localparam int USER_BITS     = 2;
endpackage

### rtl/amif_prep.sv
// Front end: magnitudes, products, determinant and numerators in four stages.
// Depends on amif_pkg.
module amif_prep #(
   parameter int WORD_BITS = amif_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = amif_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [amif_pkg::LANES-1:0][WORD_BITS-1:0] in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic [amif_pkg::LANES-1:0][2*WORD_BITS+FRAC_BITS-1:0] out_rem,
   output logic [amif_pkg::LANES-1:0] out_neg,
   output logic [2*WORD_BITS-1:0] out_den,
   output logic out_sing
);
   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int NW = 2*W+F;
   localparam int SW = 2*W+2;
   localparam int NL = amif_pkg::LANES;

   function automatic logic [SW-1:0] sval(input logic [2*W-1:0] p, input logic n);
      logic [SW-1:0] e;
      e = SW'(p);
      return n ? (~e + 1'b1) : e;
   endfunction

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // stage 1: sign and magnitude
   logic [NL-1:0][W-1:0] mag_ff, mag_in;
   logic [NL-1:0] sgn_ff, sgn_in;
   // stage 2: products, entries carried
   logic [NL-1:0][2*W-1:0] prd_ff, prd_in;
   logic [NL-1:0] psg_ff, psg_in;
   logic [3:0][W-1:0] em2_ff, em3_ff;
   logic [3:0] es2_ff, es3_ff;
   // stage 3: signed sums
   logic [SW-1:0] det_ff, det_in, gx_ff, gx_in, gy_ff, gy_in;
   // stage 4: outputs
   logic [NL-1:0][NW-1:0] rem_ff, rem_in;
   logic [NL-1:0] neg_ff, neg_in;
   logic [2*W-1:0] den_ff, den_in;
   logic sing_ff, sing_in;

   localparam int P_AD = 0, P_BC = 1, P_YC = 2, P_XD = 3, P_YA = 4, P_XB = 5;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         sgn_in[i] = in_data[i][W-1];
         mag_in[i] = in_data[i][W-1] ? (~in_data[i] + 1'b1) : in_data[i];
      end
   end

   function automatic logic [2*W-1:0] mul(input logic [W-1:0] x, input logic [W-1:0] y);
      return (2*W)'(x) * (2*W)'(y);
   endfunction

   always_comb begin
      prd_in[P_AD] = mul(mag_ff[amif_pkg::L_00], mag_ff[amif_pkg::L_11]);
      psg_in[P_AD] = sgn_ff[amif_pkg::L_00] ^ sgn_ff[amif_pkg::L_11];
      prd_in[P_BC] = mul(mag_ff[amif_pkg::L_01], mag_ff[amif_pkg::L_10]);
      psg_in[P_BC] = sgn_ff[amif_pkg::L_01] ^ sgn_ff[amif_pkg::L_10];
      prd_in[P_YC] = mul(mag_ff[amif_pkg::L_DY], mag_ff[amif_pkg::L_10]);
      psg_in[P_YC] = sgn_ff[amif_pkg::L_DY] ^ sgn_ff[amif_pkg::L_10];
      prd_in[P_XD] = mul(mag_ff[amif_pkg::L_DX], mag_ff[amif_pkg::L_11]);
      psg_in[P_XD] = sgn_ff[amif_pkg::L_DX] ^ sgn_ff[amif_pkg::L_11];
      prd_in[P_YA] = mul(mag_ff[amif_pkg::L_DY], mag_ff[amif_pkg::L_00]);
      psg_in[P_YA] = sgn_ff[amif_pkg::L_DY] ^ sgn_ff[amif_pkg::L_00];
      prd_in[P_XB] = mul(mag_ff[amif_pkg::L_DX], mag_ff[amif_pkg::L_01]);
      psg_in[P_XB] = sgn_ff[amif_pkg::L_DX] ^ sgn_ff[amif_pkg::L_01];
   end

   assign det_in = sval(prd_ff[P_AD], psg_ff[P_AD]) - sval(prd_ff[P_BC], psg_ff[P_BC]);
   assign gx_in  = sval(prd_ff[P_YC], psg_ff[P_YC]) - sval(prd_ff[P_XD], psg_ff[P_XD]);
   assign gy_in  = sval(prd_ff[P_XB], psg_ff[P_XB]) - sval(prd_ff[P_YA], psg_ff[P_YA]);

   logic [SW-1:0] det_abs, gx_abs, gy_abs;
   logic det_neg;
   always_comb begin
      det_neg = det_ff[SW-1];
      det_abs = det_neg ? (~det_ff + 1'b1) : det_ff;
      gx_abs  = gx_ff[SW-1] ? (~gx_ff + 1'b1) : gx_ff;
      gy_abs  = gy_ff[SW-1] ? (~gy_ff + 1'b1) : gy_ff;
      den_in  = det_abs[2*W-1:0];
      sing_in = (det_ff == '0);
      // adjugate entries scaled by two fraction widths, displacement numerators by one
      rem_in[amif_pkg::L_00] = NW'(em3_ff[amif_pkg::L_11]) << (2*F);
      neg_in[amif_pkg::L_00] = es3_ff[amif_pkg::L_11] ^ det_neg;
      rem_in[amif_pkg::L_01] = NW'(em3_ff[amif_pkg::L_01]) << (2*F);
      neg_in[amif_pkg::L_01] = !es3_ff[amif_pkg::L_01] ^ det_neg;
      rem_in[amif_pkg::L_10] = NW'(em3_ff[amif_pkg::L_10]) << (2*F);
      neg_in[amif_pkg::L_10] = !es3_ff[amif_pkg::L_10] ^ det_neg;
      rem_in[amif_pkg::L_11] = NW'(em3_ff[amif_pkg::L_00]) << (2*F);
      neg_in[amif_pkg::L_11] = es3_ff[amif_pkg::L_00] ^ det_neg;
      rem_in[amif_pkg::L_DX] = NW'(gx_abs[2*W-1:0]) << F;
      neg_in[amif_pkg::L_DX] = gx_ff[SW-1] ^ det_neg;
      rem_in[amif_pkg::L_DY] = NW'(gy_abs[2*W-1:0]) << F;
      neg_in[amif_pkg::L_DY] = gy_ff[SW-1] ^ det_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         mag_ff <= mag_in;
         sgn_ff <= sgn_in;
      end
      if (en2) begin
         prd_ff <= prd_in;
         psg_ff <= psg_in;
         for (int i = 0; i < 4; i++) begin
            em2_ff[i] <= mag_ff[i];
            es2_ff[i] <= sgn_ff[i];
         end
      end
      if (en3) begin
         det_ff <= det_in;
         gx_ff  <= gx_in;
         gy_ff  <= gy_in;
         em3_ff <= em2_ff;
         es3_ff <= es2_ff;
      end
      if (en4) begin
         rem_ff  <= rem_in;
         neg_ff  <= neg_in;
         den_ff  <= den_in;
         sing_ff <= sing_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_rem   = rem_ff;
   assign out_neg   = neg_ff;
   assign out_den   = den_ff;
   assign out_sing  = sing_ff;
endmodule

### rtl/amif_div.sv
// One restoring-division step for all six lanes: resolves quotient bit BIT_POS.
// Depends on amif_pkg.
module amif_div #(
   parameter int WORD_BITS = amif_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = amif_pkg::FRAC_BITS_DEF,
   parameter int BIT_POS   = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [amif_pkg::LANES-1:0][2*WORD_BITS+FRAC_BITS-1:0] in_rem,
   input  logic [amif_pkg::LANES-1:0][WORD_BITS:0] in_quo,
   input  logic [amif_pkg::LANES-1:0] in_neg,
   input  logic [2*WORD_BITS-1:0] in_den,
   input  logic in_sing,
   output logic out_valid,
   input  logic out_ready,
   output logic [amif_pkg::LANES-1:0][2*WORD_BITS+FRAC_BITS-1:0] out_rem,
   output logic [amif_pkg::LANES-1:0][WORD_BITS:0] out_quo,
   output logic [amif_pkg::LANES-1:0] out_neg,
   output logic [2*WORD_BITS-1:0] out_den,
   output logic out_sing
);
   localparam int W  = WORD_BITS;
   localparam int NW = 2*W+FRAC_BITS;
   localparam int CW = 3*W+FRAC_BITS+1;
   localparam int NL = amif_pkg::LANES;

   logic v_ff;
   logic [NL-1:0][NW-1:0] rem_ff, rem_in;
   logic [NL-1:0][W:0] quo_ff, quo_in;
   logic [NL-1:0] neg_ff;
   logic [2*W-1:0] den_ff;
   logic sing_ff;
   logic [CW-1:0] sub;
   logic [CW-1:0] diff [NL];

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      sub = CW'(in_den) << BIT_POS;
      for (int i = 0; i < NL; i++) begin
         diff[i]   = CW'(in_rem[i]) - sub;
         quo_in[i] = in_quo[i];
         rem_in[i] = in_rem[i];
         if (CW'(in_rem[i]) >= sub) begin
            rem_in[i]          = diff[i][NW-1:0];
            quo_in[i][BIT_POS] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         neg_ff  <= in_neg;
         den_ff  <= in_den;
         sing_ff <= in_sing;
      end
   end

   assign out_valid = v_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;
   assign out_neg   = neg_ff;
   assign out_den   = den_ff;
   assign out_sing  = sing_ff;
endmodule

### rtl/amif_out.sv
// Output stage: round half away from zero, saturate, apply sign, flag overflow.
// Depends on amif_pkg.
module amif_out #(
   parameter int WORD_BITS = amif_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = amif_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [amif_pkg::LANES-1:0][2*WORD_BITS+FRAC_BITS-1:0] in_rem,
   input  logic [amif_pkg::LANES-1:0][WORD_BITS:0] in_quo,
   input  logic [amif_pkg::LANES-1:0] in_neg,
   input  logic [2*WORD_BITS-1:0] in_den,
   input  logic in_sing,
   output logic out_valid,
   input  logic out_ready,
   output logic [amif_pkg::LANES-1:0][WORD_BITS-1:0] out_val,
   output logic out_sing,
   output logic out_ovf
);
   localparam int W  = WORD_BITS;
   localparam int NW = 2*W+FRAC_BITS;
   localparam int NL = amif_pkg::LANES;
   localparam logic [W+1:0] LIM_POS = {3'b000, {(W-1){1'b1}}};
   localparam logic [W+1:0] LIM_NEG = {3'b001, {(W-1){1'b0}}};

   logic v_ff;
   logic [NL-1:0][W-1:0] val_ff, val_in;
   logic sing_ff, ovf_ff, ovf_in;
   logic [W+1:0] qr  [NL];
   logic [W+1:0] lim [NL];
   logic [W-1:0] m   [NL];
   logic [NL-1:0] sat;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         qr[i]  = (W+2)'(in_quo[i]) +
                  (W+2)'(({1'b0, in_rem[i], 1'b0}) >= (NW+2)'(in_den));
         lim[i] = in_neg[i] ? LIM_NEG : LIM_POS;
         sat[i] = in_quo[i][W] || (qr[i] > lim[i]);
         m[i]   = sat[i] ? lim[i][W-1:0] : qr[i][W-1:0];
         val_in[i] = in_sing ? '0 : (in_neg[i] ? (~m[i] + 1'b1) : m[i]);
      end
      ovf_in = !in_sing && (|sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         val_ff  <= val_in;
         sing_ff <= in_sing;
         ovf_ff  <= ovf_in;
      end
   end

   assign out_valid = v_ff;
   assign out_val   = val_ff;
   assign out_sing  = sing_ff;
   assign out_ovf   = ovf_ff;
endmodule

### rtl/affine_map_inverse_from_matrix.sv
// Inverse of a planar affine map x -> x*E + d in signed fixed point: returns F = adj(E)/det(E)
// and g = -(d*F), each rounded to nearest (ties away from zero) and saturated; singular is set
// with all fields zero when det(E) is zero. The design has four front-end stages (magnitudes,
// products, sums, numerators), one restoring-division stage per quotient bit plus one for range
// detection, and a rounding stage. A new transfer is taken every cycle while backpressure has
// not filled the pipeline; each stage holds its item under backpressure and bubbles collapse.
module affine_map_inverse_from_matrix #(
   parameter int WORD_BITS = amif_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = amif_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // lin_00, lin_01, lin_10, lin_11, disp_x, disp_y, zero fill
   input  logic [((amif_pkg::LANES*WORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // inv_00, inv_01, inv_10, inv_11, inv_disp_x, inv_disp_y, zero fill
   output logic [((amif_pkg::LANES*WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // singular, overflow
   output logic [amif_pkg::USER_BITS-1:0] rsp_tuser
);
`include "affine_map_inverse_from_matrix_macros.svh"
   localparam int W  = WORD_BITS;
   localparam int NW = 2*W+FRAC_BITS;
   localparam int NL = amif_pkg::LANES;
   localparam int DB = ((NL*W+7)/8)*8;
   localparam int NS = W+2;

   logic [NL-1:0][W-1:0] in_fields, out_fields;
   logic [NL-1:0][NW-1:0] st_rem [NS];
   logic [NL-1:0][W:0] st_quo [NS];
   logic [NL-1:0] st_neg [NS];
   logic [2*W-1:0] st_den [NS];
   logic st_sing [NS];
   logic st_v [NS];
   logic st_r [NS];
   logic out_sing, out_ovf, hit_ext;

   assign in_fields = req_tdata[NL*W-1:0];
   assign st_quo[0] = '0;

   amif_prep #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (in_fields),
      .out_valid (st_v[0]),
      .out_ready (st_r[0]),
      .out_rem   (st_rem[0]),
      .out_neg   (st_neg[0]),
      .out_den   (st_den[0]),
      .out_sing  (st_sing[0])
   );

   // quotient bit W flags a result beyond the word range
   for (genvar s = 0; s <= W; s++) begin : g_div
      amif_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .BIT_POS(W - s)) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_v[s]),
         .in_ready  (st_r[s]),
         .in_rem    (st_rem[s]),
         .in_quo    (st_quo[s]),
         .in_neg    (st_neg[s]),
         .in_den    (st_den[s]),
         .in_sing   (st_sing[s]),
         .out_valid (st_v[s+1]),
         .out_ready (st_r[s+1]),
         .out_rem   (st_rem[s+1]),
         .out_quo   (st_quo[s+1]),
         .out_neg   (st_neg[s+1]),
         .out_den   (st_den[s+1]),
         .out_sing  (st_sing[s+1])
      );
   end

   amif_out #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_v[NS-1]),
      .in_ready  (st_r[NS-1]),
      .in_rem    (st_rem[NS-1]),
      .in_quo    (st_quo[NS-1]),
      .in_neg    (st_neg[NS-1]),
      .in_den    (st_den[NS-1]),
      .in_sing   (st_sing[NS-1]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_val   (out_fields),
      .out_sing  (out_sing),
      .out_ovf   (out_ovf)
   );

   assign rsp_tdata = DB'(out_fields);
   always_comb begin
      rsp_tuser = '0;
      rsp_tuser[amif_pkg::USER_SINGULAR] = out_sing;
      rsp_tuser[amif_pkg::USER_OVERFLOW] = out_ovf;
   end

   always_comb begin
      hit_ext = 1'b0;
      for (int i = 0; i < NL; i++) begin
         if (out_fields[i] == {1'b0, {(W-1){1'b1}}} || out_fields[i] == {1'b1, {(W-1){1'b0}}})
            hit_ext = 1'b1;
      end
   end

   `AMIF_ASSERT_IMP(a_sing_zero, clock, reset, rsp_tvalid && out_sing,
      rsp_tdata == '0 && !out_ovf)
   `AMIF_ASSERT_IMP(a_ovf_ext, clock, reset, rsp_tvalid && out_ovf, hit_ext)
   `AMIF_ASSERT_IMP(a_full_stall, clock, reset, !req_tready, rsp_tvalid && !rsp_tready)
   `AMIF_ASSERT_NXT(a_no_phantom, clock, reset,
      !st_v[NS-1] && !(rsp_tvalid && !rsp_tready), !rsp_tvalid)
endmodule

### tb/tb_top.sv
// Self-checking bench for affine_map_inverse_from_matrix: directed table, then random matrices.
// Predicts F = adj(E)/det(E) and g = -(d*F) with exact wide integer math.
// Depends on amif_pkg and the RTL top only.
`timescale 1ns / 1ps

module tb_top;
   localparam int W      = amif_pkg::WORD_BITS_DEF;
   localparam int FB     = amif_pkg::FRAC_BITS_DEF;
   localparam int DW     = ((amif_pkg::LANES*W+7)/8)*8;
   localparam int N_RAND = 1830;
   localparam int WD_MAX = 3000;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [W-1:0] f[amif_pkg::LANES];
      logic         sing;
      logic         ovf;
   } inverse_type;

   typedef struct {
      logic [W-1:0] m[amif_pkg::LANES];
      logic         typed;
      inverse_type  res;
   } map_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [DW-1:0] rsp_tdata;
   logic [amif_pkg::USER_BITS-1:0] rsp_tuser;

   inverse_type inverse_q[$];
   inverse_type typed_q[$];
   int  errors = 0;
   int  idle_cycles = 0;
   logic sending_typed = 0;

   always #1 clock = ~clock;

   affine_map_inverse_from_matrix i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // Round num/den to nearest, ties away from zero, then saturate to the word.
   function automatic logic [W-1:0] div_sat(input wide_type num, input wide_type den,
                                             inout logic ovf);
      logic     neg;
      wide_type nm, dm, q, r, lim;
      neg = (num < 0) != (den < 0);
      nm = (num < 0) ? -num : num;
      dm = (den < 0) ? -den : den;
      q = nm / dm;
      r = nm % dm;
      if (2 * r >= dm) q = q + 1;
      lim = neg ? (wide_type'(1) <<< (W-1)) : ((wide_type'(1) <<< (W-1)) - 1);
      if (q > lim) begin
         ovf = 1;
         q = lim;
      end
      return neg ? W'(-q) : W'(q);
   endfunction

   function automatic inverse_type invert_map(input logic [DW-1:0] data);
      inverse_type res;
      wide_type a, b, c, d, x, y, det;
      logic ovf;
      a = $signed(data[amif_pkg::L_00*W +: W]);
      b = $signed(data[amif_pkg::L_01*W +: W]);
      c = $signed(data[amif_pkg::L_10*W +: W]);
      d = $signed(data[amif_pkg::L_11*W +: W]);
      x = $signed(data[amif_pkg::L_DX*W +: W]);
      y = $signed(data[amif_pkg::L_DY*W +: W]);
      det = a*d - b*c;
      ovf = 0;
      foreach (res.f[k]) res.f[k] = '0;
      res.sing = (det == 0);
      if (!res.sing) begin
         res.f[amif_pkg::L_00] = div_sat(d <<< (2*FB), det, ovf);
         res.f[amif_pkg::L_01] = div_sat(-(b <<< (2*FB)), det, ovf);
         res.f[amif_pkg::L_10] = div_sat(-(c <<< (2*FB)), det, ovf);
         res.f[amif_pkg::L_11] = div_sat(a <<< (2*FB), det, ovf);
         res.f[amif_pkg::L_DX] = div_sat((y*c - x*d) <<< FB, det, ovf);
         res.f[amif_pkg::L_DY] = div_sat((x*b - y*a) <<< FB, det, ovf);
      end
      res.ovf = ovf;
      return res;
   endfunction

   function automatic logic [DW-1:0] pack_map(input logic [W-1:0] m[amif_pkg::LANES]);
      logic [DW-1:0] data;
      data = '0;
      foreach (m[k]) data[k*W +: W] = m[k];
      return data;
   endfunction

   function automatic logic [W-1:0] pick_value(input int kind);
      logic [W-1:0] v;
      case (kind)
         0: v = $urandom;
         1: v = W'($urandom_range(0, 1 << 19)) - W'(1 << 18);     // within +-4.0
         2: v = W'($urandom_range(0, 15)) - W'(8);                // a few lsbs
         default: begin
            case ($urandom_range(0, 5))
               0: v = {1'b1, {(W-1){1'b0}}};
               1: v = {1'b0, {(W-1){1'b1}}};
               2: v = '0;
               3: v = 1;
               4: v = '1;
               default: v = W'(1 << FB);
            endcase
         end
      endcase
      return v;
   endfunction

   function automatic void random_map(output logic [W-1:0] m[amif_pkg::LANES]);
      int sel, kind;
      sel = $urandom_range(0, 9);
      kind = (sel < 3) ? 0 : (sel < 6) ? 1 : (sel == 7) ? 2 : (sel == 8) ? 3 : 1;
      for (int k = 0; k < 4; k++) m[k] = pick_value(kind);
      if (sel == 6) begin
         // proportional rows make det exactly zero
         m[amif_pkg::L_10] = m[amif_pkg::L_00];
         m[amif_pkg::L_11] = m[amif_pkg::L_01];
         if ($urandom_range(0, 1)) begin
            m[amif_pkg::L_10] = -m[amif_pkg::L_00];
            m[amif_pkg::L_11] = -m[amif_pkg::L_01];
         end
      end
      m[amif_pkg::L_DX] = pick_value(($urandom_range(0, 2) == 0) ? 1 : 0);
      m[amif_pkg::L_DY] = pick_value(($urandom_range(0, 2) == 0) ? 1 : 0);
   endfunction

   task automatic send_map(input logic [W-1:0] m[amif_pkg::LANES]);
      req_tdata  <= pack_map(m);
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
   endtask

   // End a burst now and then, with a gap of random length.
   task automatic maybe_gap();
      if ($urandom_range(0, 7) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Record every accepted transfer.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (sending_typed) inverse_q.push_back(typed_q.pop_front());
         else inverse_q.push_back(invert_map(req_tdata));
      end
   end

   // Compare each result with the oldest expectation.
   always @(posedge clock) begin
      inverse_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (inverse_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = inverse_q.pop_front();
            for (int k = 0; k < amif_pkg::LANES; k++) begin
               if (rsp_tdata[k*W +: W] !== want.f[k]) begin
                  $display("%0t: lane %0d expected %h actual %h", $time, k, want.f[k],
                           rsp_tdata[k*W +: W]);
                  errors++;
               end
            end
            if ((rsp_tdata >> (amif_pkg::LANES*W)) !== '0) begin
               $display("%0t: fill expected 0 actual %h", $time,
                        rsp_tdata >> (amif_pkg::LANES*W));
               errors++;
            end
            if (rsp_tuser[amif_pkg::USER_SINGULAR] !== want.sing) begin
               $display("%0t: singular expected %b actual %b", $time, want.sing,
                        rsp_tuser[amif_pkg::USER_SINGULAR]);
               errors++;
            end
            if (rsp_tuser[amif_pkg::USER_OVERFLOW] !== want.ovf) begin
               $display("%0t: overflow expected %b actual %b", $time, want.ovf,
                        rsp_tuser[amif_pkg::USER_OVERFLOW]);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern: rsp_tready follows a mode that is redrawn at random.
   always @(posedge clock) begin
      int phase, mode;
      phase = phase + 1;
      if (phase % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
         0: rsp_tready <= 1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (phase % 8) < 5;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_MAX) begin
         $display("FAIL affine_map_inverse_from_matrix");
         $finish;
      end
   end

   map_row_type table_rows[$];

   function automatic map_row_type make_row(input logic [W-1:0] m[amif_pkg::LANES],
                                            input logic typed, input inverse_type res);
      map_row_type row;
      row.m = m;
      row.typed = typed;
      row.res = res;
      return row;
   endfunction

   initial begin
      logic [W-1:0] m[amif_pkg::LANES];
      inverse_type res;
      localparam logic [W-1:0] ONE  = W'(1 << FB);
      localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
      localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};

      // identity with displacement (1.0, 2.0): inverse displacement negated
      m = '{ONE, 0, 0, ONE, ONE, 2*ONE};
      res.f = '{ONE, 0, 0, ONE, -ONE, -2*ONE}; res.sing = 0; res.ovf = 0;
      table_rows.push_back(make_row(m, 1, res));
      // minus identity
      m = '{-ONE, 0, 0, -ONE, 0, 0};
      res.f = '{-ONE, 0, 0, -ONE, 0, 0}; res.sing = 0; res.ovf = 0;
      table_rows.push_back(make_row(m, 1, res));
      // zero matrix is singular
      m = '{0, 0, 0, 0, WMAX, WMIN};
      res.f = '{0, 0, 0, 0, 0, 0}; res.sing = 1; res.ovf = 0;
      table_rows.push_back(make_row(m, 1, res));
      // all entries at the negative extreme: det cancels to zero
      m = '{WMIN, WMIN, WMIN, WMIN, WMIN, WMIN};
      res.f = '{0, 0, 0, 0, 0, 0}; res.sing = 1; res.ovf = 0;
      table_rows.push_back(make_row(m, 1, res));
      // one-lsb diagonal: inverse diagonal saturates high
      m = '{1, 0, 0, 1, 0, 0};
      res.f = '{WMAX, 0, 0, WMAX, 0, 0}; res.sing = 0; res.ovf = 1;
      table_rows.push_back(make_row(m, 1, res));
      // remaining rows go through the predictor
      res.f = '{0, 0, 0, 0, 0, 0}; res.sing = 0; res.ovf = 0;
      m = '{-1, 0, 0, 1, WMAX, WMAX};                   table_rows.push_back(make_row(m, 0, res));
      m = '{WMAX, 0, 0, WMAX, WMAX, WMIN};              table_rows.push_back(make_row(m, 0, res));
      m = '{WMIN, 0, 0, WMIN, WMIN, WMAX};              table_rows.push_back(make_row(m, 0, res));
      m = '{WMAX, WMIN, WMAX, WMAX, 1, -1};             table_rows.push_back(make_row(m, 0, res));
      m = '{0, ONE, ONE, 0, 3*ONE, -5*ONE};             table_rows.push_back(make_row(m, 0, res));
      m = '{2*ONE, ONE, ONE, ONE, WMIN, WMIN};          table_rows.push_back(make_row(m, 0, res));
      m = '{3, 0, 0, 3, 1, 1};                          table_rows.push_back(make_row(m, 0, res));
      m = '{ONE/2, ONE/3, -ONE/7, 3*ONE, '1, 1};        table_rows.push_back(make_row(m, 0, res));
      m = '{ONE, ONE, ONE, ONE+1, ONE, 0};              table_rows.push_back(make_row(m, 0, res));
      m = '{'1, '1, '1, '1, '1, '1};                    table_rows.push_back(make_row(m, 0, res));

      repeat (7) @(posedge clock);
      reset <= 0;

      foreach (table_rows[i]) begin
         sending_typed <= table_rows[i].typed;
         if (table_rows[i].typed) typed_q.push_back(table_rows[i].res);
         send_map(table_rows[i].m);
         maybe_gap();
      end
      sending_typed <= 0;
      for (int i = 0; i < N_RAND; i++) begin
         random_map(m);
         send_map(m);
         maybe_gap();
      end
      req_tvalid <= 0;

      while (inverse_q.size() != 0) @(posedge clock);
      repeat (2 * (W + 6)) @(posedge clock);
      if (errors == 0) begin
         $display("PASS affine_map_inverse_from_matrix");
      end else begin
         $display("FAIL affine_map_inverse_from_matrix");
      end
      $finish;
   end
endmodule
